@@ design/frs_pkg.sv @@
// frs_pkg: shared types and constants for the frame rms sound level meter
// command and status structs between controller and datapath, log2 table
// no dependencies
package frs_pkg;

	localparam int SAMPLE_SHIFT = 6;
	localparam int SAMPLE_W     = 26;
	localparam int RAW_W        = 32;
	localparam int OFFSET_W     = 12;
	localparam int RMS_W        = 26;
	localparam int DBFS_W       = 13;
	localparam int SPL_W        = 14;
	localparam int COUNT_W      = 13;
	localparam int LOGX_W       = 13;
	localparam int LOGP_W       = 28;
	localparam int LEAD_W       = 5;

	localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 12'sd1920;
	localparam logic signed [DBFS_W-1:0]   DBFS_FLOOR   = -13'sd2560;
	localparam logic [LOGX_W-1:0]          LOG_REF      = 13'd6400;
	localparam logic [14:0]                LOG_MUL      = 15'd24660;
	localparam logic [LOGP_W-1:0]          LOG_RND      = 28'd32768;
	localparam logic [LEAD_W-1:0]          LEAD_TOP     = 5'd25;

	typedef struct packed {
		logic take;
		logic square;
		logic accum;
		logic mul_step;
		logic mul_load_s;
		logic sub_load;
		logic sqrt_step;
		logic div_load;
		logic div_step;
		logic norm_load;
		logic norm_step;
		logic logx;
		logic logm;
		logic emit;
	} frs_cmd_t;

	typedef struct packed {
		logic last;
		logic mul_last;
		logic rt_last;
		logic rms_zero;
		logic norm_top;
		logic out_busy;
	} frs_sts_t;

	// round(256*log2(1+m/16))
	function automatic logic [7:0] frac_log2(input logic [3:0] m);
		logic [7:0] r;
		case (m)
			4'd0:  r = 8'd0;
			4'd1:  r = 8'd22;
			4'd2:  r = 8'd44;
			4'd3:  r = 8'd63;
			4'd4:  r = 8'd82;
			4'd5:  r = 8'd100;
			4'd6:  r = 8'd118;
			4'd7:  r = 8'd134;
			4'd8:  r = 8'd150;
			4'd9:  r = 8'd165;
			4'd10: r = 8'd179;
			4'd11: r = 8'd193;
			4'd12: r = 8'd207;
			4'd13: r = 8'd220;
			4'd14: r = 8'd232;
			default: r = 8'd244;
		endcase
		return r;
	endfunction

endpackage

@@ design/frs_if.sv @@
// frs_if: valid/ready channel interfaces for samples and level results
// depends on frs_pkg
interface frs_in_if;
	import frs_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [RAW_W-1:0] raw_sample;
	logic                    frame_end;
	modport source(output valid, raw_sample, frame_end, input ready);
	modport sink(input valid, raw_sample, frame_end, output ready);
endinterface

interface frs_out_if;
	import frs_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [RMS_W-1:0]         rms_level;
	logic signed [DBFS_W-1:0] dbfs_q4;
	logic signed [SPL_W-1:0]  spl_q4;
	logic [COUNT_W-1:0]       frame_count;
	logic                     silent;
	modport source(output valid, rms_level, dbfs_q4, spl_q4, frame_count, silent,
		input ready);
	modport sink(input valid, rms_level, dbfs_q4, spl_q4, frame_count, silent,
		output ready);
endinterface

@@ design/frs_ctrl.sv @@
// frs_ctrl: sequencer for accumulation and the end-of-frame math
// depends on frs_pkg
module frs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  frs_pkg::frs_sts_t sts,
	output frs_pkg::frs_cmd_t cmd
);
	import frs_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_SQ   = 12'b000000000010,
		ST_ACC  = 12'b000000000100,
		ST_MULQ = 12'b000000001000,
		ST_MULS = 12'b000000010000,
		ST_SUB  = 12'b000000100000,
		ST_SQRT = 12'b000001000000,
		ST_DIV  = 12'b000010000000,
		ST_NORM = 12'b000100000000,
		ST_LOGX = 12'b001000000000,
		ST_LOGM = 12'b010000000000,
		ST_EMIT = 12'b100000000000
	} state_t;

	state_t state_q, state_nx;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_nx = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.square = 1'b1;
				state_nx   = ST_ACC;
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				state_nx  = sts.last ? ST_MULQ : ST_IDLE;
			end
			ST_MULQ: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) begin
					cmd.mul_load_s = 1'b1;
					state_nx       = ST_MULS;
				end
			end
			ST_MULS: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) begin
					state_nx = ST_SUB;
				end
			end
			ST_SUB: begin
				cmd.sub_load = 1'b1;
				state_nx     = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.rt_last) begin
					cmd.div_load = 1'b1;
					state_nx     = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.rt_last) begin
					cmd.norm_load = 1'b1;
					state_nx      = ST_NORM;
				end
			end
			ST_NORM: begin
				if (sts.rms_zero) begin
					state_nx = ST_EMIT;
				end else if (sts.norm_top) begin
					state_nx = ST_LOGX;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			ST_LOGX: begin
				cmd.logx = 1'b1;
				state_nx = ST_LOGM;
			end
			ST_LOGM: begin
				cmd.logm = 1'b1;
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

@@ design/frs_dp.sv @@
// frs_dp: accumulators, shift-add multiplier, bitwise sqrt, divider, log
// depends on frs_pkg
module frs_dp #(
	parameter int MAX_FRAME = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  frs_pkg::frs_cmd_t                      cmd,
	output frs_pkg::frs_sts_t                      sts,
	input  logic signed [frs_pkg::RAW_W-1:0]       raw_sample,
	input  logic                                   frame_end,
	input  logic                                   cfg_we,
	input  logic signed [frs_pkg::OFFSET_W-1:0]    cfg_wdata,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic [frs_pkg::RMS_W-1:0]              rms_level,
	output logic signed [frs_pkg::DBFS_W-1:0]      dbfs_q4,
	output logic signed [frs_pkg::SPL_W-1:0]       spl_q4,
	output logic [frs_pkg::COUNT_W-1:0]            frame_count,
	output logic                                   silent
);
	import frs_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W;
	localparam int SQ_W  = 2 * SAMPLE_W - 1 + CNT_W;
	localparam int RT_W  = SAMPLE_W + CNT_W;
	localparam int NUM_W = 2 * RT_W;
	localparam int IT_W  = $clog2(SUM_W);

	// sample capture and square
	logic signed [SAMPLE_W-1:0] smp_q;
	logic                       fend_q;
	logic [SAMPLE_W-1:0]        mag;
	logic [2*SAMPLE_W-1:0]      sq_q;

	// open frame accumulators
	logic signed [SUM_W-1:0] sum_q, sum_nx;
	logic [SQ_W-1:0]         sqs_q, sqs_nx;
	logic [CNT_W-1:0]        tally_q, tally_nx;

	// end-of-frame datapath
	logic [CNT_W-1:0]     n_q;
	logic [SUM_W-1:0]     smag;
	logic [SUM_W-1:0]     smag_q_hold;
	logic [NUM_W-1:0]     ma_q, mp_q, mp_step, num_q;
	logic [SUM_W-1:0]     mb_q;
	logic [IT_W-1:0]      it_q;
	logic [RT_W+1:0]      rem_q, rem2, trial;
	logic [RT_W-1:0]      root_q, root_nx;
	logic                 rt_ge;
	logic [RT_W-1:0]      dq_q, dq_nx;
	logic [CNT_W-1:0]     drem_q;
	logic [CNT_W:0]       dr2;
	logic                 d_ge;
	logic [RMS_W-1:0]     rms_q, nrm_q;
	logic [LEAD_W-1:0]    k_q;
	logic [LEAD_W-1:0]    lead_p;
	logic [LOGX_W-1:0]    x_q;
	logic [LOGP_W-1:0]    lp_q;
	logic signed [OFFSET_W-1:0] off_q;
	logic signed [DBFS_W-1:0]   dbfs_nx;
	logic                 ov_q;

	assign mag      = smp_q[SAMPLE_W-1] ? SAMPLE_W'(-smp_q) : SAMPLE_W'(smp_q);
	assign sum_nx   = sum_q + SUM_W'(smp_q);
	assign sqs_nx   = sqs_q + SQ_W'(sq_q);
	assign tally_nx = tally_q + 1'b1;
	assign smag     = sum_nx[SUM_W-1] ? SUM_W'(-sum_nx) : SUM_W'(sum_nx);

	assign mp_step  = mp_q + (mb_q[0] ? ma_q : '0);

	assign rem2     = {rem_q[RT_W-1:0], num_q[NUM_W-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign rt_ge    = (rem2 >= trial);
	assign root_nx  = {root_q[RT_W-2:0], rt_ge};

	assign dr2      = {drem_q, dq_q[RT_W-1]};
	assign d_ge     = (dr2 >= {1'b0, n_q});
	assign dq_nx    = {dq_q[RT_W-2:0], d_ge};

	assign lead_p   = LEAD_TOP - k_q;
	assign dbfs_nx  = -DBFS_W'(lp_q >> 16);

	assign sts.last     = fend_q || (tally_nx == CNT_W'(MAX_FRAME));
	assign sts.mul_last = (it_q == IT_W'(SUM_W - 1));
	assign sts.rt_last  = (it_q == IT_W'(RT_W - 1));
	assign sts.rms_zero = (rms_q == '0);
	assign sts.norm_top = nrm_q[RMS_W-1];
	assign sts.out_busy = ov_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			smp_q  <= SAMPLE_W'(raw_sample >>> SAMPLE_SHIFT);
			fend_q <= frame_end;
		end
		if (cmd.square) begin
			sq_q <= mag * mag;
		end
		if (cmd.accum && sts.last) begin
			n_q  <= tally_nx;
			ma_q <= NUM_W'(sqs_nx);
			mb_q <= SUM_W'(tally_nx);
			mp_q <= '0;
			it_q <= '0;
		end else if (cmd.mul_load_s) begin
			num_q <= mp_step;
			ma_q  <= NUM_W'(smag_q_hold);
			mb_q  <= smag_q_hold;
			mp_q  <= '0;
			it_q  <= '0;
		end else if (cmd.mul_step) begin
			ma_q <= {ma_q[NUM_W-2:0], 1'b0};
			mb_q <= {1'b0, mb_q[SUM_W-1:1]};
			mp_q <= mp_step;
			it_q <= it_q + 1'b1;
		end
		if (cmd.sub_load) begin
			num_q  <= num_q - mp_q;
			rem_q  <= '0;
			root_q <= '0;
			it_q   <= '0;
		end
		if (cmd.sqrt_step) begin
			rem_q  <= rt_ge ? (rem2 - trial) : rem2;
			root_q <= root_nx;
			num_q  <= {num_q[NUM_W-3:0], 2'b00};
			it_q   <= it_q + 1'b1;
		end
		if (cmd.div_load) begin
			dq_q   <= root_nx;
			drem_q <= '0;
			it_q   <= '0;
		end
		if (cmd.div_step) begin
			drem_q <= d_ge ? CNT_W'(dr2 - {1'b0, n_q}) : CNT_W'(dr2);
			dq_q   <= dq_nx;
			it_q   <= it_q + 1'b1;
		end
		if (cmd.norm_load) begin
			rms_q <= dq_nx[RMS_W-1:0];
			nrm_q <= dq_nx[RMS_W-1:0];
			k_q   <= '0;
		end
		if (cmd.norm_step) begin
			nrm_q <= {nrm_q[RMS_W-2:0], 1'b0};
			k_q   <= k_q + 1'b1;
		end
		if (cmd.logx) begin
			x_q <= LOG_REF - ({lead_p, 8'b0} + LOGX_W'(frac_log2(nrm_q[RMS_W-2 -: 4])));
		end
		if (cmd.logm) begin
			lp_q <= LOGP_W'(x_q) * LOGP_W'(LOG_MUL) + LOG_RND;
		end
		if (cmd.emit) begin
			rms_level   <= rms_q;
			silent      <= sts.rms_zero;
			frame_count <= COUNT_W'(n_q);
			dbfs_q4     <= sts.rms_zero ? DBFS_FLOOR : dbfs_nx;
			spl_q4      <= SPL_W'(sts.rms_zero ? DBFS_FLOOR : dbfs_nx) + SPL_W'(off_q);
		end
	end

	// magnitude of the frame sum, kept for the second product
	always_ff @(posedge clk) begin
		if (cmd.accum && sts.last) begin
			smag_q_hold <= smag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sqs_q   <= '0;
			tally_q <= '0;
			off_q   <= OFFSET_RESET;
			ov_q    <= 1'b0;
		end else begin
			if (cmd.accum) begin
				if (sts.last) begin
					sum_q   <= '0;
					sqs_q   <= '0;
					tally_q <= '0;
				end else begin
					sum_q   <= sum_nx;
					sqs_q   <= sqs_nx;
					tally_q <= tally_nx;
				end
			end
			if (cfg_we) begin
				off_q <= cfg_wdata;
			end
			if (cmd.emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;

`ifndef SYNTHESIS
	// variance numerator can never go negative
	a_num_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sub_load |-> (num_q >= mp_q))
		else $error("frs_dp: negative variance numerator");

	// rms never exceeds full scale
	a_rms_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.norm_load |-> (dq_nx <= RT_W'(33554432)))
		else $error("frs_dp: rms above full scale");

	// a result is loaded only into a free or draining output slot
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(ov_q && !out_ready))
		else $error("frs_dp: result overwrote a pending transfer");

	// a loaded result is visible in the next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> ov_q)
		else $error("frs_dp: emitted result not valid");
`endif

endmodule

@@ design/frame_rms_sound_level.sv @@
// frame_rms_sound_level: top level of the frame rms level meter
// depends on frs_pkg, frs_if, frs_ctrl, frs_dp
//
//  channel   dir  transfer moves
//  samples   in   raw_sample (32b signed), frame_end
//  levels    out  rms_level, dbfs_q4, spl_q4, frame_count, silent
//  cfg       in   cfg_we / cfg_wdata: spl_offset_q4 (12b signed)
//
// a sample passes through capture, 26x26 square and accumulate
// the last sample of a frame adds the end-of-frame sequence:
//   2*(26+CW) shift-add multiply steps, 1 subtract, 26+CW sqrt steps,
//   26+CW divide steps, normalize shifts until the leading one is on top,
//   2 log steps, 1 load (CW = clog2(MAX_FRAME+1)); a zero rms skips normalize and log
// samples is not ready during that sequence; results sit in an output
//   register, so a stalled levels channel holds only the final load
// reset clears the accumulators, sets the offset to 1920 and empties the output
module frame_rms_sound_level #(
	parameter int MAX_FRAME = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	frs_in_if.sink                              samples,
	frs_out_if.source                           levels,
	input  logic                                cfg_we,
	input  logic signed [frs_pkg::OFFSET_W-1:0] cfg_wdata
);
	import frs_pkg::*;

	frs_cmd_t cmd;
	frs_sts_t sts;

	// sequencer: owns the sample ready and the step order
	frs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: sums, multiply, sqrt, divide, log, output register
	frs_dp #(
		.MAX_FRAME (MAX_FRAME)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.raw_sample  (samples.raw_sample),
		.frame_end   (samples.frame_end),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_ready   (levels.ready),
		.out_valid   (levels.valid),
		.rms_level   (levels.rms_level),
		.dbfs_q4     (levels.dbfs_q4),
		.spl_q4      (levels.spl_q4),
		.frame_count (levels.frame_count),
		.silent      (levels.silent)
	);

endmodule

@@ tb/sv/frame_rms_sound_level_tb.sv @@
// frame_rms_sound_level_tb: self-checking testbench for the frame rms level meter
// drives sample frames, predicts each frame's level result and compares every transfer
// depends on frs_pkg, frs_if and frame_rms_sound_level
module frame_rms_sound_level_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import frs_pkg::*;

	localparam int FRAME_MAX   = 4096;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 300;   // outlasts the longest end-of-frame sequence

	typedef struct packed {
		logic [RMS_W-1:0]         rms;
		logic signed [DBFS_W-1:0] dbfs;
		logic signed [SPL_W-1:0]  spl;
		logic [COUNT_W-1:0]       count;
		logic                     silent;
	} level_t;

	// one row of the directed part; known = expected result typed in by hand
	typedef struct {
		logic [RAW_W-1:0] raw;
		logic             last;
		logic             known;
		level_t           lvl;
	} stim_row_t;

	typedef enum int {MIX_FULL, MIX_QUIET, MIX_CONST, MIX_RAILS} mix_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic signed [OFFSET_W-1:0] cfg_wdata;

	frs_in_if  samples();
	frs_out_if levels();

	frame_rms_sound_level DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.levels    (levels),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state: open-frame accumulators and the offset register copy
	longint            acc_sum;
	logic [127:0]      acc_sq;
	int                acc_n;
	logic signed [OFFSET_W-1:0] offset_copy;

	level_t pending_levels[$];   // expected results, oldest first
	int     errors;
	int     cycles;
	int     n_items;
	int     n_levels;
	int     n_silent;
	int     idle_pct;
	int     hold_cycles;         // receiver hold-off, counted down by its own process

	const logic [7:0] log_frac[16] = '{0, 22, 44, 63, 82, 100, 118, 134,
		150, 165, 179, 193, 207, 220, 232, 244};

	// clock: 20 ns period
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// drive every input to a known value from time zero
	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		samples.valid      = 1'b0;
		samples.raw_sample = '0;
		samples.frame_end  = 1'b0;
		levels.ready       = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_levels.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n)
			levels.ready <= 1'b0;
		else if (hold_cycles > 0) begin
			levels.ready <= 1'b0;
			hold_cycles  <= hold_cycles - 1;
		end else
			levels.ready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("[%0d] mismatch %s: got %0d expected %0d", cycles, what, got, want);
	endtask

	// result checker: every level transfer against the oldest expectation
	always @(posedge clk) begin
		level_t want;
		if (arst_n && levels.valid && levels.ready) begin
			if (pending_levels.size() == 0)
				report("unexpected result, rms", levels.rms_level, -1);
			else begin
				want = pending_levels.pop_front();
				n_levels++;
				if (levels.rms_level !== want.rms)
					report("rms_level", levels.rms_level, want.rms);
				if (levels.dbfs_q4 !== want.dbfs)
					report("dbfs_q4", levels.dbfs_q4, want.dbfs);
				if (levels.spl_q4 !== want.spl)
					report("spl_q4", levels.spl_q4, want.spl);
				if (levels.frame_count !== want.count)
					report("frame_count", levels.frame_count, want.count);
				if (levels.silent !== want.silent)
					report("silent", levels.silent, want.silent);
			end
		end
	end

	// level in 1/16 dB from leading-one position and a 4-bit mantissa
	function automatic logic signed [DBFS_W-1:0] dbfs_of(input logic [RMS_W-1:0] rms);
		int     lead;
		int     mant;
		longint span;
		lead = 0;
		for (int i = 0; i < RMS_W; i++)
			if (rms[i])
				lead = i;
		if (lead >= 4)
			mant = (rms >> (lead - 4)) & 15;
		else
			mant = (rms << (4 - lead)) & 15;
		span = 6400 - (lead * 256 + log_frac[mant]);
		return -DBFS_W'((span * 24660 + 32768) >>> 16);
	endfunction

	// accumulate one accepted sample; on frame close queue the expected level
	function automatic void accumulate_sample(input logic [RAW_W-1:0] raw, input logic last);
		logic signed [SAMPLE_W-1:0] s;
		logic [127:0] num;
		logic [127:0] sum_mag;
		logic [63:0]  root;
		logic [63:0]  trial;
		level_t       lvl;
		s = SAMPLE_W'($signed(raw) >>> SAMPLE_SHIFT);
		acc_sum += s;
		acc_sq  += 128'(longint'(s) * longint'(s));
		acc_n++;
		if (!last && acc_n < FRAME_MAX)
			return;
		// n*q - s*s is never negative; integer sqrt then divide by n
		sum_mag = 128'(acc_sum < 0 ? -acc_sum : acc_sum);
		num = acc_sq * 128'(acc_n) - sum_mag * sum_mag;
		root = '0;
		for (int b = 41; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (128'(trial) * 128'(trial) <= num)
				root = trial;
		end
		lvl.rms    = RMS_W'(root / 64'(acc_n));
		lvl.silent = (lvl.rms == 0);
		lvl.dbfs   = lvl.silent ? DBFS_FLOOR : dbfs_of(lvl.rms);
		lvl.spl    = SPL_W'(lvl.dbfs) + SPL_W'(offset_copy);
		lvl.count  = COUNT_W'(acc_n);
		if (lvl.silent)
			n_silent++;
		pending_levels.push_back(lvl);
		acc_sum = 0;
		acc_sq  = '0;
		acc_n   = 0;
	endfunction

	// offer one sample, with random gaps; valid stays up into the next call
	task automatic send_sample(input logic [RAW_W-1:0] raw, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			samples.valid <= 1'b0;
			@(negedge clk);
		end
		samples.valid      <= 1'b1;
		samples.raw_sample <= raw;
		samples.frame_end  <= last;
		do
			@(posedge clk);
		while (!samples.ready);
		accumulate_sample(raw, last);
		n_items++;
		@(negedge clk);
	endtask

	task automatic stop_sending;
		samples.valid     <= 1'b0;
		samples.frame_end <= 1'b0;
		@(negedge clk);
	endtask

	// wait for all expected levels, then for the block to settle
	task automatic drain;
		stop_sending();
		wait (pending_levels.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_offset(input logic signed [OFFSET_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we      <= 1'b0;
		offset_copy = value;
	endtask

	function automatic logic [RAW_W-1:0] pick_raw(input mix_t mix, input logic [RAW_W-1:0] base);
		logic [RAW_W-1:0] r;
		case (mix)
			MIX_FULL:  r = $urandom;
			MIX_QUIET: r = RAW_W'($signed($urandom_range(8191)) - 4096) << SAMPLE_SHIFT
				| $urandom_range(63);
			MIX_CONST: r = base | $urandom_range(63);   // low bits are shifted away
			default:   r = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
		return r;
	endfunction

	// whole frames with random length and sample character
	task automatic send_frames(input int n_frames);
		int               len;
		int               sel;
		mix_t             mix;
		logic [RAW_W-1:0] base;
		for (int f = 0; f < n_frames; f++) begin
			sel = $urandom_range(99);
			if (sel < 10)
				len = 1;
			else if (sel < 80)
				len = $urandom_range(24, 2);
			else
				len = $urandom_range(100, 25);
			mix  = mix_t'($urandom_range(3));
			base = $urandom & ~32'h3F;
			for (int i = 0; i < len; i++)
				send_sample(pick_raw(mix, base), i == len - 1);
		end
	endtask

	stim_row_t directed[$];

	function automatic stim_row_t row(input logic [RAW_W-1:0] raw, input logic last,
		input logic known, input logic [COUNT_W-1:0] count);
		stim_row_t r;
		r.raw        = raw;
		r.last       = last;
		r.known      = known;
		r.lvl.rms    = '0;
		r.lvl.silent = 1'b1;
		r.lvl.dbfs   = DBFS_FLOOR;
		r.lvl.spl    = SPL_W'(DBFS_FLOOR) + SPL_W'(OFFSET_RESET);
		r.lvl.count  = count;
		return r;
	endfunction

	initial begin
		level_t typed;
		errors      = 0;
		cycles      = 0;
		n_items     = 0;
		n_levels    = 0;
		n_silent    = 0;
		idle_pct    = 36;
		hold_cycles = 0;
		acc_sum     = 0;
		acc_sq      = '0;
		acc_n       = 0;
		offset_copy = OFFSET_RESET;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		// directed: zero frame, rails, shift boundaries, constant frames
		directed.push_back(row(32'h0000_0000, 1'b1, 1'b1, 13'd1)); // single zero: floor
		directed.push_back(row(32'h7FFF_FFFF, 1'b0, 1'b0, 13'd0)); // alternating rails
		directed.push_back(row(32'h8000_0000, 1'b1, 1'b0, 13'd0));
		directed.push_back(row(32'h0000_003F, 1'b0, 1'b0, 13'd0)); // shifts to 0
		directed.push_back(row(32'hFFFF_FFC0, 1'b0, 1'b0, 13'd0)); // shifts to -1
		directed.push_back(row(32'h0000_0040, 1'b1, 1'b0, 13'd0)); // shifts to +1
		directed.push_back(row(32'h8000_0000, 1'b1, 1'b1, 13'd1)); // single negative rail
		directed.push_back(row(32'h1234_5678, 1'b0, 1'b0, 13'd0)); // constant pair: silent
		directed.push_back(row(32'h1234_5678, 1'b1, 1'b1, 13'd2));
		directed.push_back(row(32'h7FFF_FFFF, 1'b0, 1'b0, 13'd0));
		directed.push_back(row(32'h8000_0000, 1'b0, 1'b0, 13'd0));
		directed.push_back(row(32'h7FFF_FFFF, 1'b0, 1'b0, 13'd0));
		directed.push_back(row(32'h8000_0000, 1'b1, 1'b0, 13'd0));
		directed.push_back(row(32'h0000_0FC0, 1'b0, 1'b0, 13'd0)); // small spread, low level
		directed.push_back(row(32'h0000_1000, 1'b1, 1'b0, 13'd0));
		directed.push_back(row(32'hFFFF_FFFF, 1'b0, 1'b0, 13'd0));
		directed.push_back(row(32'h0000_0000, 1'b1, 1'b0, 13'd0));
		foreach (directed[i]) begin
			send_sample(directed[i].raw, directed[i].last);
			// hand-typed expectation replaces the predicted one for known rows
			if (directed[i].known) begin
				typed = pending_levels.pop_back();
				if (typed !== directed[i].lvl)
					report("predictor vs typed, rms", typed.rms, directed[i].lvl.rms);
				pending_levels.push_back(directed[i].lvl);
			end
		end

		// offset extremes and random settings across random frames
		write_offset(-12'sd2048);
		send_frames(10);
		write_offset(12'sd2047);
		send_frames(10);
		write_offset(12'sd0);
		idle_pct = 0;            // stretch with no gaps on either side
		send_frames(8);
		idle_pct = 36;
		write_offset(OFFSET_W'($urandom));

		// receiver holds off while frames keep coming: input must stall
		drain();
		hold_cycles = 800;
		send_frames(6);
		drain();                 // sender pauses until everything has arrived
		write_offset(OFFSET_W'($urandom));
		send_frames(8);
		write_offset(OFFSET_RESET);
		send_frames(5);

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d samples, %0d levels (%0d silent)",
			n_items, n_levels, n_silent);
		$display("offset swept through both extremes, zero and random values; %0d errors",
			errors);
		if (errors == 0 && pending_levels.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
